>>> rtl/checked_int32_alu_macros.svh
// ---------------------------------------------------------------------------
// checked_int32_alu_macros: assertion helpers
// Shorthand for clocked assertions with asynchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef CHECKED_INT32_ALU_MACROS_SVH
`define CHECKED_INT32_ALU_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CIA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cia_pkg.sv
// ---------------------------------------------------------------------------
// cia_pkg: shared types and codes
// Operation and status codes for the checked integer ALU.
// ---------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned OpWidth     = 4;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_NEG = 4'd5,
    OP_LT  = 4'd6,
    OP_GT  = 4'd7,
    OP_NE  = 4'd8,
    OP_EQ  = 4'd9
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

endpackage

>>> rtl/cia_if.sv
// ---------------------------------------------------------------------------
// cia_if: word channels
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface cia_req_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   operation;
  logic signed [DATA_WIDTH-1:0] lhs;
  logic signed [DATA_WIDTH-1:0] rhs;

  modport source (output valid, operation, lhs, rhs, input ready);
  modport sink   (input valid, operation, lhs, rhs, output ready);
endinterface

interface cia_rsp_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         flag;
  logic [1:0]                   status;

  modport source (output valid, value, flag, status, input ready);
  modport sink   (input valid, value, flag, status, output ready);
endinterface

>>> rtl/checked_int32_alu.sv
// Path: a request word passes the input register, the stage-2 register,
// the divider stages and the output register before its result is valid.
// Throughput: one word per cycle when not stalled; the divider is fully
// pipelined, one quotient bit per stage, and every operation travels the
// same stages. A result-side stall freezes the whole pipe; nothing is lost.
// Reset: asynchronous, active low; clears all valid bits.
// ---------------------------------------------------------------------------
// checked_int32_alu: overflow-checked signed integer ALU
// Add, sub, mul, div, rem, negate and compares; value is zeroed on error status.
// ---------------------------------------------------------------------------
`include "checked_int32_alu_macros.svh"

module checked_int32_alu
  import cia_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic   clk_i,
  input logic   rst_ni,
  cia_req_if.sink   req,
  cia_rsp_if.source rsp
);

  localparam int unsigned W = DATA_WIDTH;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic               neg;
    logic [W-1:0]       early;
    logic               flag;
    logic [1:0]         status;
    logic               fin;
  } tag_t;

  logic en;
  logic out_v_q;
  assign en        = !out_v_q || rsp.ready;
  assign req.ready = en;

  // stage 1: register inputs
  logic             s1_v_q;
  logic [3:0]       s1_op_q;
  logic signed [W-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= req.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= req.operation;
      s1_a_q  <= req.lhs;
      s1_b_q  <= req.rhs;
    end
  end

  // stage 2: magnitudes, add/sub/negate/compare, multiply, divide checks
  logic [W-1:0] ma, mb;
  logic         sgn_neg;
  logic signed [W:0] sum_w, dif_w, neg_w;
  logic [2*W-1:0] prod;
  tag_t s1_tag;
  logic minv_a, b_m1;

  always_comb begin
    ma      = s1_a_q[W-1] ? W'(-s1_a_q) : W'(s1_a_q);
    mb      = s1_b_q[W-1] ? W'(-s1_b_q) : W'(s1_b_q);
    sgn_neg = s1_a_q[W-1] ^ s1_b_q[W-1];
    sum_w   = (W+1)'(s1_a_q) + (W+1)'(s1_b_q);
    dif_w   = (W+1)'(s1_a_q) - (W+1)'(s1_b_q);
    neg_w   = -(W+1)'(s1_a_q);
    prod    = (2*W)'(ma) * (2*W)'(mb);
    minv_a  = (s1_a_q == {1'b1, {(W-1){1'b0}}});
    b_m1    = (s1_b_q == {W{1'b1}});
    s1_tag  = '0;
    s1_tag.op  = s1_op_q;
    s1_tag.neg = sgn_neg;
    s1_tag.fin = 1'b1;
    unique case (s1_op_q)
      OP_ADD: begin
        if (sum_w[W] != sum_w[W-1]) s1_tag.status = ST_OVF;
        else s1_tag.early = sum_w[W-1:0];
      end
      OP_SUB: begin
        if (dif_w[W] != dif_w[W-1]) s1_tag.status = ST_OVF;
        else s1_tag.early = dif_w[W-1:0];
      end
      OP_NEG: begin
        if (neg_w[W] != neg_w[W-1]) s1_tag.status = ST_OVF;
        else s1_tag.early = neg_w[W-1:0];
      end
      OP_LT: s1_tag.flag = s1_a_q < s1_b_q;
      OP_GT: s1_tag.flag = s1_a_q > s1_b_q;
      OP_NE: s1_tag.flag = s1_a_q != s1_b_q;
      OP_EQ: s1_tag.flag = s1_a_q == s1_b_q;
      OP_MUL: s1_tag.fin = 1'b0;
      OP_DIV: begin
        if (s1_b_q == '0) s1_tag.status = ST_DIVZ;
        else if (minv_a && b_m1) s1_tag.status = ST_OVF;
        else s1_tag.fin = 1'b0;
      end
      OP_REM: begin
        if (s1_b_q == '0) s1_tag.status = ST_DIVZ;
        else if (!b_m1) s1_tag.fin = 1'b0;
      end
      default: ;
    endcase
    s1_tag.neg = (s1_op_q == OP_REM) ? s1_a_q[W-1] : sgn_neg;
  end

  logic           s2_v_q;
  tag_t           s2_tag_q;
  logic [2*W-1:0] s2_prod_q;
  logic [W-1:0]   s2_ma_q, s2_mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_tag_q  <= s1_tag;
      s2_prod_q <= prod;
      s2_ma_q   <= ma;
      s2_mb_q   <= mb;
    end
  end

  // stage 3: resolve multiply, then divider pipe carries everything
  tag_t s2_tag;
  logic [W-1:0] lim;
  always_comb begin
    s2_tag = s2_tag_q;
    lim    = s2_tag_q.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    if (s2_tag_q.op == OP_MUL) begin
      s2_tag.fin = 1'b1;
      if (s2_prod_q > (2*W)'(lim)) s2_tag.status = ST_OVF;
      else s2_tag.early = s2_tag_q.neg ? W'(-s2_prod_q[W-1:0]) : s2_prod_q[W-1:0];
    end
  end

  logic         dv_v;
  logic [W-1:0] dv_q, dv_r;
  tag_t         dv_tag;

  cia_divider #(
    .W    (W),
    .TagW ($bits(tag_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .num_i   (s2_ma_q),
    .den_i   (s2_mb_q),
    .tag_i   (s2_tag),
    .valid_o (dv_v),
    .quo_o   (dv_q),
    .rem_o   (dv_r),
    .tag_o   (dv_tag)
  );

  // final stage: sign fix, output register
  logic [W-1:0] mag, fin_val;
  logic [W-1:0] out_val_q;
  logic         out_flag_q;
  logic [1:0]   out_st_q;

  always_comb begin
    mag     = (dv_tag.op == OP_REM) ? dv_r : dv_q;
    fin_val = dv_tag.fin ? dv_tag.early : (dv_tag.neg ? W'(-mag) : mag);
    if (dv_tag.status != ST_OK) fin_val = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q  <= fin_val;
      out_flag_q <= dv_tag.flag;
      out_st_q   <= dv_tag.status;
    end
  end

  assign rsp.valid  = out_v_q;
  assign rsp.value  = out_val_q;
  assign rsp.flag   = out_flag_q;
  assign rsp.status = out_st_q;

  `CIA_ASSERT_NEXT(a_stall_hold, out_v_q && !rsp.ready, out_v_q && $stable(out_val_q),
    "result word changed under stall")
  `CIA_ASSERT_IMP(a_val_zero, out_v_q && out_st_q != ST_OK, out_val_q == '0,
    "nonzero value with error status")
  `CIA_ASSERT_IMP(a_flag_zero, out_v_q && out_st_q != ST_OK, !out_flag_q,
    "flag set with error status")

endmodule

>>> rtl/cia_divider.sv
// ---------------------------------------------------------------------------
// cia_divider: pipelined restoring divider
// Unsigned magnitude division, one quotient bit per stage, with stall.
// ---------------------------------------------------------------------------
module cia_divider
  import cia_pkg::*;
#(
  parameter int unsigned W = 32,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [W-1:0]    num_i,
  input  logic [W-1:0]    den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [W-1:0]    quo_o,
  output logic [W-1:0]    rem_o,
  output logic [TagW-1:0] tag_o
);

  logic            vld_q [W];
  logic [W-1:0]    num_q [W];
  logic [W-1:0]    den_q [W];
  logic [W-1:0]    rem_q [W];
  logic [TagW-1:0] tag_q [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic            in_v;
    logic [W-1:0]    in_num;
    logic [W-1:0]    in_den;
    logic [W-1:0]    in_rem;
    logic [TagW-1:0] in_tag;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic [W-1:0]    rem_d;
    logic [W-1:0]    num_d;

    if (s == 0) begin : g_head
      assign in_v   = valid_i;
      assign in_num = num_i;
      assign in_den = den_i;
      assign in_rem = '0;
      assign in_tag = tag_i;
    end else begin : g_body
      assign in_v   = vld_q[s-1];
      assign in_num = num_q[s-1];
      assign in_den = den_q[s-1];
      assign in_rem = rem_q[s-1];
      assign in_tag = tag_q[s-1];
    end

    always_comb begin
      trial = {in_rem, in_num[W-1]};
      diff  = trial - {1'b0, in_den};
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        num_d = {in_num[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        num_d = {in_num[W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= in_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_d;
        rem_q[s] <= rem_d;
        den_q[s] <= in_den;
        tag_q[s] <= in_tag;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign quo_o   = num_q[W-1];
  assign rem_o   = rem_q[W-1];
  assign tag_o   = tag_q[W-1];

endmodule

>>> tb/checked_int32_alu_tb_if.sv
// ---------------------------------------------------------------------------
// checked_int32_alu_tb_if: testbench view of the word channels
// The block's own interfaces are reused; this file names the width
// the bench builds them with and sets the time unit.
// ---------------------------------------------------------------------------
package checked_int32_alu_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TbWidth = 32;
endpackage

>>> tb/checked_int32_alu_tb.sv
// ---------------------------------------------------------------------------
// checked_int32_alu_tb: self-checking bench for the checked integer ALU
// Drives a directed table of extremes and error cases, then random
// operations under varying sender and receiver idling, and compares each
// result word against an in-bench prediction of value, flag and status.
// ---------------------------------------------------------------------------
module checked_int32_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cia_pkg::*;
  import checked_int32_alu_tb_pkg::*;

  localparam int unsigned W = TbWidth;
  localparam int unsigned WdLimit = 20000;
  localparam logic signed [W-1:0] MaxV = 32'sh7fffffff;
  localparam logic signed [W-1:0] MinV = 32'sh80000000;

  typedef struct packed {
    logic [3:0]          operation;
    logic signed [W-1:0] lhs;
    logic signed [W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                flag;
    logic [1:0]          status;
  } alu_rsp_t;

  typedef struct packed {
    alu_req_t req;
    logic     known;
    alu_rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cia_req_if #(.DATA_WIDTH(W)) req ();
  cia_rsp_if #(.DATA_WIDTH(W)) rsp ();

  checked_int32_alu #(.DATA_WIDTH(W)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  alu_rsp_t    pending_rsp[$];
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic alu_rsp_t alu_predict(alu_req_t r);
    alu_rsp_t     o;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] res;
    a = r.lhs;
    b = r.rhs;
    res = 0;
    o.flag = 1'b0;
    o.status = ST_OK;
    case (r.operation)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: res = a * b;
      OP_DIV: begin
        if (b == 0) o.status = ST_DIVZ;
        else res = a / b;
      end
      OP_REM: begin
        if (b == 0) o.status = ST_DIVZ;
        else res = a % b;
      end
      OP_NEG: res = -a;
      OP_LT:  o.flag = a < b;
      OP_GT:  o.flag = a > b;
      OP_NE:  o.flag = a != b;
      OP_EQ:  o.flag = a == b;
      default: ;
    endcase
    if (o.status == ST_OK && (res > 64'sd2147483647 || res < -64'sd2147483648))
      o.status = ST_OVF;
    o.value = (o.status == ST_OK) ? res[W-1:0] : '0;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] exp);
    $display("mismatch %s: got %h exp %h at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  task automatic send_word(alu_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.operation <= r.operation;
    req.lhs       <= r.lhs;
    req.rhs       <= r.rhs;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp.push_back(alu_predict(r));
  endtask

  function automatic logic signed [W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return MaxV;
      1: return MinV;
      2: return 0;
      3: return -1;
      4: return 1;
      5: return $signed($urandom_range(65535)) - 32768;
      6: return $signed(32'($urandom_range(255))) - 128;
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t r;
    r.operation = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                            : 4'($urandom_range(9));
    r.lhs = pick_operand();
    r.rhs = pick_operand();
    if (r.operation == OP_MUL && $urandom_range(1)) begin
      r.lhs = $signed(32'($urandom_range(131071))) - 65536;
      r.rhs = $signed(32'($urandom_range(131071))) - 65536;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_off) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected word", rsp.value, '0);
      end else begin
        alu_rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.value !== e.value) report_mismatch("value", rsp.value, e.value);
        if (rsp.flag !== e.flag) report_mismatch("flag", 32'(rsp.flag), 32'(e.flag));
        if (rsp.status !== e.status)
          report_mismatch("status", 32'(rsp.status), 32'(e.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WdLimit);
    $display("FAIL checked_int32_alu");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    alu_req_t r;
    alu_rsp_t e;
    int unsigned phase;
    int unsigned n;
    rows = '{
      '{'{OP_ADD, MaxV, 32'sd1}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_ADD, MinV, -32'sd1}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_ADD, MaxV, MinV}, 1'b1, '{-32'sd1, 1'b0, ST_OK}},
      '{'{OP_SUB, MinV, 32'sd1}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_SUB, 32'sd0, MinV}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_SUB, -32'sd1, MinV}, 1'b1, '{MaxV, 1'b0, ST_OK}},
      '{'{OP_MUL, MinV, -32'sd1}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_MUL, MinV, 32'sd1}, 1'b1, '{MinV, 1'b0, ST_OK}},
      '{'{OP_MUL, 32'sd65536, 32'sd32768}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_MUL, -32'sd65536, 32'sd32768}, 1'b1, '{MinV, 1'b0, ST_OK}},
      '{'{OP_MUL, MaxV, MaxV}, 1'b0, '0},
      '{'{OP_DIV, MaxV, 32'sd0}, 1'b1, '{32'sd0, 1'b0, ST_DIVZ}},
      '{'{OP_DIV, MinV, -32'sd1}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_DIV, -32'sd7, 32'sd2}, 1'b1, '{-32'sd3, 1'b0, ST_OK}},
      '{'{OP_REM, MinV, 32'sd0}, 1'b1, '{32'sd0, 1'b0, ST_DIVZ}},
      '{'{OP_REM, MinV, -32'sd1}, 1'b1, '{32'sd0, 1'b0, ST_OK}},
      '{'{OP_REM, -32'sd7, 32'sd2}, 1'b1, '{-32'sd1, 1'b0, ST_OK}},
      '{'{OP_NEG, MinV, 32'sd5}, 1'b1, '{32'sd0, 1'b0, ST_OVF}},
      '{'{OP_NEG, MaxV, MinV}, 1'b1, '{-MaxV, 1'b0, ST_OK}},
      '{'{OP_LT, MinV, MaxV}, 1'b1, '{32'sd0, 1'b1, ST_OK}},
      '{'{OP_GT, MinV, MaxV}, 1'b1, '{32'sd0, 1'b0, ST_OK}},
      '{'{OP_NE, MaxV, MaxV}, 1'b1, '{32'sd0, 1'b0, ST_OK}},
      '{'{OP_EQ, MinV, MinV}, 1'b1, '{32'sd0, 1'b1, ST_OK}},
      '{'{4'd15, -32'sd1, -32'sd1}, 1'b1, '0},
      '{'{4'd10, MaxV, 32'sd0}, 1'b1, '0}
    };
    err_cnt       = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = 1'b0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.operation = '0;
    req.lhs       = '0;
    req.rhs       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        e = alu_predict(rows[i].req);
        if (e !== rows[i].rsp)
          report_mismatch("table row", 32'(i), 32'(e.value));
      end
      send_word(rows[i].req);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 23 : 0;
      for (n = 0; n < 340; n++) begin
        if (phase == 2 && n == 40) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (200) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        r = rand_req();
        send_word(r);
      end
    end
    req.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (2 * W + 8) @(posedge clk_i);
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("PASS checked_int32_alu");
    end else begin
      $display("FAIL checked_int32_alu");
    end
    $finish;
  end
endmodule
